// File: rtl/qha_pkg.sv
// ----------------------------------------------------------------------------
// qha_pkg
// Shared types, constants and the arctangent table for the quaternion
// heading azimuth block.
// ----------------------------------------------------------------------------
package qha_pkg;

  // fixed-point formats
  localparam int FRACTION_BITS     = 14;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int QUAT_W            = 16;
  localparam int CFG_W             = 15;
  localparam int AZ_W              = 16;
  localparam int PROD_W            = 32;
  localparam int ACC_W             = 33;
  localparam int COMP_W            = 35;
  localparam int MAG_W             = 34;
  localparam int CORD_W            = 44;
  localparam int ANG_W             = 32;
  localparam int ANG_FRAC          = 16;

  // normalisation: larger magnitude brought into [2^40, 2^41)
  localparam int NORM_BIT          = 40;
  localparam int COARSE_BIT        = 32;
  localparam int COARSE_SHIFT      = 8;

  // arctangent table
  localparam int TABLE_LEN         = 24;
  localparam int TIDX_W            = 5;

  // configuration reset values
  localparam logic [CFG_W-1:0] TILT_RESET = 15'd13107;
  localparam logic [CFG_W-1:0] EPS_RESET  = 15'd1;

  // 1.0 at twice the fraction bits
  localparam logic signed [COMP_W-1:0] UNIT_VAL =
    {{(COMP_W-1){1'b0}}, 1'b1} << (2 * FRACTION_BITS);

  // angles in centidegrees * 2^16
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'd589824000;
  localparam logic [ANG_W-1:0] HALF_TURN    = 32'd1179648000;
  localparam logic [ANG_W-1:0] FULL_TURN    = 32'd2359296000;
  localparam logic [ANG_W-1:0] ROUND_BIAS   = 32'd32768;
  localparam logic [AZ_W:0]    CENTIDEG_TURN = 17'd36000;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TILT = 1'b0,
    REG_EPS  = 1'b1
  } cfg_reg_e;

  // product schedule of the shared multiplier
  typedef enum logic [2:0] {
    P_XY = 3'd0,
    P_WZ = 3'd1,
    P_XX = 3'd2,
    P_ZZ = 3'd3,
    P_YZ = 3'd4,
    P_WX = 3'd5,
    P_XZ = 3'd6,
    P_WY = 3'd7
  } prod_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEL,
    ST_CHECK,
    ST_NORM,
    ST_ROT,
    ST_QUAD,
    ST_ROUND,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              mul_en;
    prod_e             mul_sel;
    logic              acc_en;
    prod_e             acc_sel;
    logic              sel_en;
    logic              check_en;
    logic              norm_en;
    logic              rot_en;
    logic [TIDX_W-1:0] rot_idx;
    logic              quad_en;
    logic              round_en;
    logic              emit;
    logic              upd;
  } qha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic degenerate;
    logic zero_vec;
    logic norm_done;
  } qha_status_t;

  // atan(2^-i) in centidegrees * 2^16, rounded to nearest
  function automatic logic [ANG_W-1:0] atan_entry(input logic [TIDX_W-1:0] idx);
    logic [ANG_W-1:0] val;
    case (idx)
      5'd0:    val = 32'd294912000;
      5'd1:    val = 32'd174096719;
      5'd2:    val = 32'd91987925;
      5'd3:    val = 32'd46694507;
      5'd4:    val = 32'd23437865;
      5'd5:    val = 32'd11730358;
      5'd6:    val = 32'd5866610;
      5'd7:    val = 32'd2933484;
      5'd8:    val = 32'd1466764;
      5'd9:    val = 32'd733385;
      5'd10:   val = 32'd366693;
      5'd11:   val = 32'd183346;
      5'd12:   val = 32'd91673;
      5'd13:   val = 32'd45837;
      5'd14:   val = 32'd22918;
      5'd15:   val = 32'd11459;
      5'd16:   val = 32'd5730;
      5'd17:   val = 32'd2865;
      5'd18:   val = 32'd1432;
      5'd19:   val = 32'd716;
      5'd20:   val = 32'd358;
      5'd21:   val = 32'd179;
      5'd22:   val = 32'd90;
      5'd23:   val = 32'd45;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/quaternion_heading_azimuth.sv
// ----------------------------------------------------------------------------
// quaternion_heading_azimuth
// Compass heading from a rotation quaternion, clockwise from north in
// hundredths of a degree.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: quat_x/y/z/w (signed Q1.14) with in_valid_i / in_stall_o.
//   A transaction is taken at an edge with valid high and stall low; the
//   block then works on that one sample and stalls the input until it has
//   placed the result in its output register.
//   Output channel: azimuth, valid flag and updated flag with out_valid_o /
//   out_stall_i; exactly one result per input transaction.
//   Configuration: cfg_we_i / cfg_idx_i / cfg_wdata_i, written while idle.
//   Steps: the eight products run on one shared multiplier, then the
//   heading vector is chosen and checked, normalised by shifting and
//   rotated by one CORDIC iteration per cycle; a skipped sample goes from
//   the checks straight to the output, and a zero heading vector skips
//   normalisation and the CORDIC.
//   While the receiver stalls, the result is held and the next sample may be
//   fully computed; it then waits until the output register frees up.
//   Reset clears the held azimuth and valid flag and restores the thresholds.
// ----------------------------------------------------------------------------
module quaternion_heading_azimuth #(
  parameter int CORDIC_ITERATIONS = qha_pkg::CORDIC_ITERATIONS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [qha_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [qha_pkg::QUAT_W-1:0]  quat_x_i,
  input  logic signed [qha_pkg::QUAT_W-1:0]  quat_y_i,
  input  logic signed [qha_pkg::QUAT_W-1:0]  quat_z_i,
  input  logic signed [qha_pkg::QUAT_W-1:0]  quat_w_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [qha_pkg::AZ_W-1:0]           azimuth_centideg_o,
  output logic                               heading_valid_o,
  output logic                               heading_updated_o
);
  import qha_pkg::*;

  qha_cmd_t    cmd;
  qha_status_t status;

  // sequencer
  qha_ctrl #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and held state
  qha_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .quat_x_i           (quat_x_i),
    .quat_y_i           (quat_y_i),
    .quat_z_i           (quat_z_i),
    .quat_w_i           (quat_w_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .azimuth_centideg_o (azimuth_centideg_o),
    .heading_valid_o    (heading_valid_o),
    .heading_updated_o  (heading_updated_o)
  );

endmodule

// File: rtl/qha_datapath.sv
// ----------------------------------------------------------------------------
// qha_datapath
// Configuration registers, shared multiplier with accumulators, heading
// vector selection, normalisation, iterative CORDIC, quadrant mapping and
// the held azimuth with the output register.
// ----------------------------------------------------------------------------
module qha_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [qha_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic signed [qha_pkg::QUAT_W-1:0]    quat_x_i,
  input  logic signed [qha_pkg::QUAT_W-1:0]    quat_y_i,
  input  logic signed [qha_pkg::QUAT_W-1:0]    quat_z_i,
  input  logic signed [qha_pkg::QUAT_W-1:0]    quat_w_i,
  input  qha_pkg::qha_cmd_t                    cmd_i,
  output qha_pkg::qha_status_t                 status_o,
  output logic [qha_pkg::AZ_W-1:0]             azimuth_centideg_o,
  output logic                                 heading_valid_o,
  output logic                                 heading_updated_o
);
  import qha_pkg::*;

  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [COMP_W-1:0] v);
    logic signed [COMP_W-1:0] n;
    n = -v;
    return v[COMP_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  logic [CFG_W-1:0]           tilt_q, eps_q;
  logic signed [QUAT_W-1:0]   qx_q, qy_q, qz_q, qw_q;
  logic signed [QUAT_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    ey_q, ns_q, u_q, ez_q, nz_q;
  logic signed [COMP_W-1:0]   uy_e, uy_n, uy_u, fz_e, fz_n;
  logic [MAG_W-1:0]           tilt_lim, eps_lim;
  logic                       use_top;
  logic signed [COMP_W-1:0]   he_q, hn_q;
  logic [MAG_W-1:0]           he_mag, hn_mag;
  logic signed [CORD_W-1:0]   x_q, y_q, xs, ys;
  logic signed [ANG_W-1:0]    z_q, atan_val;
  logic                       coarse;
  logic [ANG_W-1:0]           zc, az_d, az_q;
  logic [ANG_W:0]             biased;
  logic [AZ_W:0]              rounded;
  logic [AZ_W-1:0]            round_d, round_q;
  logic [AZ_W-1:0]            held_az_q;
  logic                       have_q;
  logic [AZ_W-1:0]            out_az_q;
  logic                       out_have_q, out_upd_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q <= TILT_RESET;
      eps_q  <= EPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TILT: tilt_q <= cfg_wdata_i;
        REG_EPS:  eps_q  <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // capture of the accepted quaternion
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qx_q <= quat_x_i;
      qy_q <= quat_y_i;
      qz_q <= quat_z_i;
      qw_q <= quat_w_i;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      P_XY:    begin op_a = qx_q; op_b = qy_q; end
      P_WZ:    begin op_a = qw_q; op_b = qz_q; end
      P_XX:    begin op_a = qx_q; op_b = qx_q; end
      P_ZZ:    begin op_a = qz_q; op_b = qz_q; end
      P_YZ:    begin op_a = qy_q; op_b = qz_q; end
      P_WX:    begin op_a = qw_q; op_b = qx_q; end
      P_XZ:    begin op_a = qx_q; op_b = qz_q; end
      P_WY:    begin op_a = qw_q; op_b = qy_q; end
      default: begin op_a = qx_q; op_b = qy_q; end
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign prod_ext = ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // accumulate products into the rotated component sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ey_q <= '0;
      ns_q <= '0;
      u_q  <= '0;
      ez_q <= '0;
      nz_q <= '0;
    end else if (cmd_i.acc_en) begin
      case (cmd_i.acc_sel)
        P_XY:    ey_q <= ey_q + prod_ext;
        P_WZ:    ey_q <= ey_q - prod_ext;
        P_XX:    ns_q <= ns_q + prod_ext;
        P_ZZ:    ns_q <= ns_q + prod_ext;
        P_YZ:    begin
          u_q  <= u_q + prod_ext;
          nz_q <= nz_q + prod_ext;
        end
        P_WX:    begin
          u_q  <= u_q + prod_ext;
          nz_q <= nz_q - prod_ext;
        end
        P_XZ:    ez_q <= ez_q + prod_ext;
        P_WY:    ez_q <= ez_q + prod_ext;
        default: ;
      endcase
    end
  end

  // rotated axes and heading vector choice
  always_comb begin
    uy_e     = COMP_W'(ey_q) <<< 1;
    uy_n     = UNIT_VAL - (COMP_W'(ns_q) <<< 1);
    uy_u     = COMP_W'(u_q) <<< 1;
    fz_e     = -(COMP_W'(ez_q) <<< 1);
    fz_n     = -(COMP_W'(nz_q) <<< 1);
    tilt_lim = MAG_W'(tilt_q) << FRACTION_BITS;
    use_top  = abs_mag(uy_u) < tilt_lim;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_en) begin
      he_q <= use_top ? uy_e : fz_e;
      hn_q <= use_top ? uy_n : fz_n;
    end
  end

  // degenerate and zero vector checks, normalisation status and CORDIC shift terms
  always_comb begin
    he_mag              = abs_mag(he_q);
    hn_mag              = abs_mag(hn_q);
    eps_lim             = MAG_W'(eps_q) << FRACTION_BITS;
    status_o.degenerate = (he_mag < eps_lim) && (hn_mag < eps_lim);
    status_o.zero_vec   = (he_q == '0) && (hn_q == '0);
    status_o.norm_done  = (|x_q[CORD_W-1:NORM_BIT]) || (|y_q[CORD_W-1:NORM_BIT]);
    coarse              = ~(|x_q[CORD_W-1:COARSE_BIT]) && ~(|y_q[CORD_W-1:COARSE_BIT]);
    xs                  = x_q >>> cmd_i.rot_idx;
    ys                  = y_q >>> cmd_i.rot_idx;
    atan_val            = signed'(atan_entry(cmd_i.rot_idx));
  end

  // cordic load, normalisation and vectoring iterations
  always_ff @(posedge clk_i) begin
    if (cmd_i.check_en) begin
      x_q <= signed'(CORD_W'(hn_mag));
      y_q <= signed'(CORD_W'(he_mag));
      z_q <= '0;
    end else if (cmd_i.norm_en) begin
      x_q <= coarse ? (x_q <<< COARSE_SHIFT) : (x_q <<< 1);
      y_q <= coarse ? (y_q <<< COARSE_SHIFT) : (y_q <<< 1);
    end else if (cmd_i.rot_en) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_val;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_val;
      end
    end
  end

  // clamp and map the first-quadrant angle to its quadrant
  always_comb begin
    if (z_q < 0) begin
      zc = '0;
    end else if (z_q > signed'(QUARTER_TURN)) begin
      zc = QUARTER_TURN;
    end else begin
      zc = unsigned'(z_q);
    end
    if (!hn_q[COMP_W-1] && !he_q[COMP_W-1]) begin
      az_d = zc;
    end else if (hn_q[COMP_W-1] && !he_q[COMP_W-1]) begin
      az_d = HALF_TURN - zc;
    end else if (hn_q[COMP_W-1]) begin
      az_d = HALF_TURN + zc;
    end else begin
      az_d = FULL_TURN - zc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.quad_en) begin
      az_q <= az_d;
    end
  end

  // round half up to centidegrees and wrap the full circle
  always_comb begin
    biased  = {1'b0, az_q} + {1'b0, ROUND_BIAS};
    rounded = biased[ANG_W:ANG_FRAC];
    if (rounded >= CENTIDEG_TURN) begin
      round_d = AZ_W'(rounded - CENTIDEG_TURN);
    end else begin
      round_d = AZ_W'(rounded);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_en) begin
      round_q <= round_d;
    end
  end

  // held heading state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_az_q <= '0;
      have_q    <= 1'b0;
    end else if (cmd_i.emit && cmd_i.upd) begin
      held_az_q <= round_q;
      have_q    <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_az_q   <= cmd_i.upd ? round_q : held_az_q;
      out_have_q <= cmd_i.upd | have_q;
      out_upd_q  <= cmd_i.upd;
    end
  end

  assign azimuth_centideg_o = out_az_q;
  assign heading_valid_o    = out_have_q;
  assign heading_updated_o  = out_upd_q;

endmodule

// File: rtl/qha_ctrl.sv
// ----------------------------------------------------------------------------
// qha_ctrl
// Sequencer for one transaction: product schedule, selection, checks,
// normalisation, cordic iterations, rounding and the output handshake.
// ----------------------------------------------------------------------------
module qha_ctrl #(
  parameter int CORDIC_ITERATIONS = qha_pkg::CORDIC_ITERATIONS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  qha_pkg::qha_status_t  status_i,
  output qha_pkg::qha_cmd_t     cmd_o
);
  import qha_pkg::*;

  localparam int RotSteps = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
  localparam int SelW     = $bits(prod_e);
  localparam int MulSteps = 2 ** SelW;
  localparam int CntW     = $clog2(((RotSteps > MulSteps) ? RotSteps : MulSteps) + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_m1;
  logic            upd_q, upd_d;
  logic            out_valid_q, out_valid_d;

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cnt_m1 = cnt_q - 1'b1;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    upd_d          = upd_q;
    out_valid_d    = out_valid_q & out_stall_i;
    cmd_o          = '0;
    cmd_o.mul_sel  = prod_e'(cnt_q[SelW-1:0]);
    cmd_o.acc_sel  = prod_e'(cnt_m1[SelW-1:0]);
    cmd_o.rot_idx  = TIDX_W'(cnt_q);
    cmd_o.upd      = upd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = cnt_q < CntW'(MulSteps);
        cmd_o.acc_en = cnt_q != '0;
        if (cnt_q == CntW'(MulSteps)) begin
          state_d = ST_SEL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SEL: begin
        cmd_o.sel_en = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check_en = 1'b1;
        if (status_i.degenerate) begin
          upd_d   = 1'b0;
          state_d = ST_EMIT;
        end else begin
          upd_d   = 1'b1;
          state_d = status_i.zero_vec ? ST_QUAD : ST_NORM;
        end
      end
      ST_NORM: begin
        if (status_i.norm_done) begin
          cnt_d   = '0;
          state_d = ST_ROT;
        end else begin
          cmd_o.norm_en = 1'b1;
        end
      end
      ST_ROT: begin
        cmd_o.rot_en = 1'b1;
        if (cnt_q == CntW'(RotSteps - 1)) begin
          state_d = ST_QUAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_QUAD: begin
        cmd_o.quad_en = 1'b1;
        state_d       = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
